// ===== design/rpfa_pkg.sv =====
package rpfa_pkg;

    // Default sizing of the pool
    localparam int NUM_REGS_DEF    = 18;
    localparam int SYMBOL_BITS_DEF = 16;

    // Port field widths
    localparam int SYM_W      = 16;
    localparam int MASK_W     = 18;
    localparam int REG_IDX_W  = 5;
    localparam int ACT_W      = 2;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 24;

    // Result action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_STORE = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_GRANT = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Update of the allocation-order queue
    typedef struct packed {
        logic                 push;   // append entry at the tail
        logic                 evict;  // remove at pos, append entry at the tail
        logic [REG_IDX_W-1:0] pos;
        logic [REG_IDX_W-1:0] entry;
    } t_aq_ctrl;

endpackage

// ===== design/rpfa_age_queue.sv =====
module rpfa_age_queue #(
    parameter int NUM_REGS = rpfa_pkg::NUM_REGS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rpfa_pkg::t_aq_ctrl           i_ctrl,
    input  logic [$clog2(NUM_REGS)-1:0]  i_rd_pos,
    output logic [$clog2(NUM_REGS)-1:0]  o_rd_entry,
    output logic [$clog2(NUM_REGS+1)-1:0] o_count
);

    localparam int IdxW = $clog2(NUM_REGS);
    localparam int CntW = $clog2(NUM_REGS + 1);

    logic [IdxW-1:0] r_q [NUM_REGS];
    logic [CntW-1:0] r_count;
    logic [IdxW-1:0] w_pos;
    logic [IdxW-1:0] w_entry;

    assign w_pos      = i_ctrl.pos[IdxW-1:0];
    assign w_entry    = i_ctrl.entry[IdxW-1:0];
    assign o_rd_entry = r_q[i_rd_pos];
    assign o_count    = r_count;

    // Track the number of allocated registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + CntW'(1);
        end
    end

    // Shift out the evicted entry and append the newest at the tail
    for (genvar k = 0; k < NUM_REGS; k++) begin : g_slot
        if (k < NUM_REGS - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ctrl.push && CntW'(k) == r_count) begin
                    r_q[k] <= w_entry;
                end else if (i_ctrl.evict && CntW'(k) + CntW'(1) == r_count) begin
                    r_q[k] <= w_entry;
                end else if (i_ctrl.evict && IdxW'(k) >= w_pos
                             && CntW'(k) + CntW'(1) < r_count) begin
                    r_q[k] <= r_q[k+1];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (i_ctrl.push && CntW'(k) == r_count) begin
                    r_q[k] <= w_entry;
                end else if (i_ctrl.evict && CntW'(k) + CntW'(1) == r_count) begin
                    r_q[k] <= w_entry;
                end
            end
        end
    end

endmodule

// ===== design/register_pool_fifo_allocator.sv =====
// Register pool allocator: maps symbols onto NUM_REGS registers like a fully
// associative cache with FIFO replacement. Each request (tuser = kind, tdata =
// symbol, spillable, forbid mask) yields one to three results in the order
// store, load, grant, or a single "no register" result; tlast marks the final
// one. One pool read port serves the register walk and the update: the block
// first walks the registers one per cycle looking for a hit and the lowest
// free allowed register (a hit ends the walk early, a miss walks them all);
// when no free register qualifies it walks the allocation order one entry per
// cycle for the oldest allowed victim. A miss that finds a register updates the
// pool in an update state, and results are presented one per cycle while the
// output is not stalled; the input is not ready until the grant has been
// placed in the output register, and a new request may be taken while it
// waits. A no-register result frees the input in the same way.
module register_pool_fifo_allocator #(
    parameter int NUM_REGS    = rpfa_pkg::NUM_REGS_DEF,
    parameter int SYMBOL_BITS = rpfa_pkg::SYMBOL_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rpfa_pkg::IN_DATA_W-1:0]  i_s_tdata,  // symbol, spillable, forbid_mask
    input  logic                            i_s_tuser,  // kind
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rpfa_pkg::OUT_DATA_W-1:0] o_m_tdata,  // reg_index, symbol_out
    output logic [rpfa_pkg::ACT_W-1:0]      o_m_tuser,  // action
    output logic                            o_m_tlast
);

    localparam int IdxW = $clog2(NUM_REGS);
    localparam int CntW = $clog2(NUM_REGS + 1);
    localparam int SymW = SYMBOL_BITS;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_AQ    = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_STORE = 8'b0001_0000,
        S_LOAD  = 8'b0010_0000,
        S_GRANT = 8'b0100_0000,
        S_NONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Request
    logic                        r_kind;
    logic [SymW-1:0]             r_sym;
    logic                        r_spill;
    logic [rpfa_pkg::MASK_W-1:0] r_mask;

    // Search
    logic [IdxW-1:0] r_idx;
    logic            r_free_found;
    logic [IdxW-1:0] r_free_idx;
    logic [IdxW-1:0] r_target;
    logic [IdxW-1:0] r_pos;
    logic            r_from_free;
    logic [SymW-1:0] r_old_sym;

    // Register pool state
    logic [SymW-1:0]     r_sym_arr [NUM_REGS];
    logic [NUM_REGS-1:0] r_valid;
    logic [NUM_REGS-1:0] r_dirty;
    logic [NUM_REGS-1:0] r_spl;

    // Output register
    logic                       r_out_valid;
    rpfa_pkg::t_action          r_out_act;
    logic [rpfa_pkg::REG_IDX_W-1:0] r_out_reg;
    logic [rpfa_pkg::SYM_W-1:0] r_out_sym;
    logic                       r_out_last;

    logic                 w_accept;
    logic                 w_out_free;
    logic [IdxW-1:0]      w_rd_addr;
    logic [SymW-1:0]      w_rd_sym;
    logic                 w_hit;
    logic                 w_free_here;
    logic                 w_scan_end;
    logic                 w_store;
    logic [31:0]          w_mask32;
    logic [31:0]          w_in_sym32;
    logic [31:0]          w_old_sym32;
    logic [31:0]          w_req_sym32;
    logic [IdxW-1:0]      w_aq_entry;
    logic [CntW-1:0]      w_aq_count;
    logic                 w_aq_allowed;
    logic                 w_aq_end;
    rpfa_pkg::t_aq_ctrl   w_aq_ctrl;

    function automatic logic f_forbidden(input logic [31:0] mask, input logic [IdxW-1:0] r);
        f_forbidden = mask[5'(r)];
    endfunction

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_mask32    = 32'(r_mask);
    assign w_in_sym32  = 32'(i_s_tdata[rpfa_pkg::SYM_W-1:0]);
    assign w_old_sym32 = 32'(r_old_sym);
    assign w_req_sym32 = 32'(r_sym);

    // Shared pool read port and search checks: one register or queue entry per cycle
    assign w_rd_addr   = (r_state == S_SCAN) ? r_idx : r_target;
    assign w_rd_sym    = r_sym_arr[w_rd_addr];
    assign w_hit       = r_valid[r_idx] && (w_rd_sym == r_sym);
    assign w_free_here = !r_valid[r_idx] && !f_forbidden(w_mask32, r_idx);
    assign w_scan_end  = (r_idx == IdxW'(NUM_REGS - 1));
    assign w_store     = r_valid[r_target] && r_dirty[r_target] && r_spl[r_target];
    assign w_aq_allowed = !f_forbidden(w_mask32, w_aq_entry);
    assign w_aq_end    = (CntW'(r_idx) + CntW'(1) == w_aq_count);

    // Update allocation order once the target is known
    always_comb begin
        w_aq_ctrl       = '0;
        w_aq_ctrl.pos   = rpfa_pkg::REG_IDX_W'(r_pos);
        w_aq_ctrl.entry = rpfa_pkg::REG_IDX_W'(r_target);
        if (r_state == S_UPD) begin
            w_aq_ctrl.push  = r_from_free;
            w_aq_ctrl.evict = !r_from_free;
        end
    end

    rpfa_age_queue #(
        .NUM_REGS (NUM_REGS)
    ) u_age_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_aq_ctrl),
        .i_rd_pos   (r_idx),
        .o_rd_entry (w_aq_entry),
        .o_count    (w_aq_count)
    );

    // Sequence the search, the update and the results
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_GRANT;
                end else if (w_scan_end) begin
                    if (r_free_found || w_free_here) n_state = S_UPD;
                    else if (w_aq_count == '0)       n_state = S_NONE;
                    else                             n_state = S_AQ;
                end
            end
            S_AQ: begin
                if (w_aq_allowed)  n_state = S_UPD;
                else if (w_aq_end) n_state = S_NONE;
            end
            S_UPD: begin
                if (w_store)      n_state = S_STORE;
                else if (!r_kind) n_state = S_LOAD;
                else              n_state = S_GRANT;
            end
            S_STORE: begin
                if (w_out_free) n_state = r_kind ? S_GRANT : S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) n_state = S_GRANT;
            end
            S_GRANT, S_NONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the request and step the search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_kind       <= i_s_tuser;
                        r_sym        <= w_in_sym32[SymW-1:0];
                        r_spill      <= i_s_tdata[rpfa_pkg::SYM_W];
                        r_mask       <= i_s_tdata[rpfa_pkg::SYM_W+rpfa_pkg::MASK_W:
                                                  rpfa_pkg::SYM_W+1];
                        r_idx        <= '0;
                        r_free_found <= 1'b0;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_target <= r_idx;
                    end else if (w_scan_end) begin
                        r_from_free <= 1'b1;
                        r_target    <= r_free_found ? r_free_idx : r_idx;
                        r_idx       <= '0;
                    end else begin
                        if (w_free_here && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_idx;
                        end
                        r_idx <= r_idx + IdxW'(1);
                    end
                end
                S_AQ: begin
                    if (w_aq_allowed) begin
                        r_from_free <= 1'b0;
                        r_target    <= w_aq_entry;
                        r_pos       <= r_idx;
                    end else begin
                        r_idx <= r_idx + IdxW'(1);
                    end
                end
                S_UPD: begin
                    r_old_sym <= w_rd_sym;
                end
                default: ;
            endcase
        end
    end

    // Write the pool state: dirty on a write hit, full remap on a miss
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_dirty <= '0;
            r_spl   <= '0;
        end else if (r_state == S_SCAN && w_hit && r_kind) begin
            r_dirty[r_idx] <= 1'b1;
        end else if (r_state == S_UPD) begin
            r_valid[r_target] <= 1'b1;
            r_dirty[r_target] <= r_kind;
            r_spl[r_target]   <= r_spill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_sym_arr[r_target] <= r_sym;
        end
    end

    // Load the output register, drop it when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free && (r_state == S_STORE || r_state == S_LOAD
                                    || r_state == S_GRANT || r_state == S_NONE)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            case (r_state)
                S_STORE: begin
                    r_out_act  <= rpfa_pkg::ACT_STORE;
                    r_out_reg  <= rpfa_pkg::REG_IDX_W'(r_target);
                    r_out_sym  <= w_old_sym32[rpfa_pkg::SYM_W-1:0];
                    r_out_last <= 1'b0;
                end
                S_LOAD: begin
                    r_out_act  <= rpfa_pkg::ACT_LOAD;
                    r_out_reg  <= rpfa_pkg::REG_IDX_W'(r_target);
                    r_out_sym  <= w_req_sym32[rpfa_pkg::SYM_W-1:0];
                    r_out_last <= 1'b0;
                end
                S_GRANT: begin
                    r_out_act  <= rpfa_pkg::ACT_GRANT;
                    r_out_reg  <= rpfa_pkg::REG_IDX_W'(r_target);
                    r_out_sym  <= w_req_sym32[rpfa_pkg::SYM_W-1:0];
                    r_out_last <= 1'b1;
                end
                S_NONE: begin
                    r_out_act  <= rpfa_pkg::ACT_NONE;
                    r_out_reg  <= '0;
                    r_out_sym  <= w_req_sym32[rpfa_pkg::SYM_W-1:0];
                    r_out_last <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_act;
    assign o_m_tdata  = {{(rpfa_pkg::OUT_DATA_W - rpfa_pkg::SYM_W - rpfa_pkg::REG_IDX_W){1'b0}},
                         r_out_sym, r_out_reg};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== design/rpfa_checker.sv =====
module rpfa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rpfa_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic [rpfa_pkg::ACT_W-1:0]      o_m_tuser,
    input logic                            o_m_tlast
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Stay busy after taking a request
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while previous one in progress");

    // Take no request while an intermediate result is shown
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> !o_s_tready)
        else $error("ready during a multi-result request");

    // Store and load never end a request, grant and no-register always do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tuser == rpfa_pkg::ACT_GRANT
                                      || o_m_tuser == rpfa_pkg::ACT_NONE)))
        else $error("tlast does not match action");

    // No-register result refers to register zero
    a_none_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == rpfa_pkg::ACT_NONE
            |-> o_m_tdata[rpfa_pkg::REG_IDX_W-1:0] == '0)
        else $error("no-register result with nonzero index");

endmodule

bind register_pool_fifo_allocator rpfa_checker u_rpfa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
